/* rtl/gfp_pkg.sv */
// Package: shared types and constants of the grid rectangle packer.
package gfp_pkg;

   localparam int GFP_MAX_COLS = 64;
   localparam int GFP_MAX_ROWS = 64;

   localparam int GFP_PX_W     = 12;
   localparam int GFP_DIM_W    = 7;
   localparam int GFP_SHIFT_W  = 4;
   localparam int GFP_POS_W    = 6;
   localparam int GFP_CSR_IX_W = 2;

   typedef enum logic [1:0] {
      ST_PLACED  = 2'd0,
      ST_NO_ROOM = 2'd1,
      ST_SKIPPED = 2'd2,
      ST_CLEARED = 2'd3
   } gfp_status_type;

   typedef enum logic {
      CMD_CLEAR = 1'b0,
      CMD_PLACE = 1'b1
   } gfp_cmd_type;

   typedef enum logic [GFP_CSR_IX_W-1:0] {
      CSR_GRID_COLS  = 2'd0,
      CSR_GRID_ROWS  = 2'd1,
      CSR_CELL_SHIFT = 2'd2,
      CSR_UNUSED     = 2'd3
   } gfp_csr_ix_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ROW,
      S_RD,
      S_ACC,
      S_SCAN,
      S_MRD,
      S_MWR
   } gfp_state_type;

endpackage

/* rtl/gfp_ifs.sv */
// Interfaces: request, response and register write channels of the packer.
interface gfp_req_if import gfp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 command;
   logic [GFP_PX_W-1:0]  rect_width_px;
   logic [GFP_PX_W-1:0]  rect_height_px;
   logic                 excluded;
   modport source (output valid, command, rect_width_px, rect_height_px, excluded,
                   input ready);
   modport sink   (input valid, command, rect_width_px, rect_height_px, excluded,
                   output ready);
endinterface

interface gfp_rsp_if import gfp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [1:0]           status;
   logic [GFP_POS_W-1:0] pos_col;
   logic [GFP_POS_W-1:0] pos_row;
   modport source (output valid, status, pos_col, pos_row, input ready);
   modport sink   (input valid, status, pos_col, pos_row, output ready);
endinterface

interface gfp_csr_if import gfp_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [GFP_CSR_IX_W-1:0] index;
   logic [GFP_DIM_W-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/grid_rect_first_fit_packer.sv */
// Top level: occupancy-grid first-fit rectangle packer.
// The grid lives in a row-wide synchronous memory, one word per grid row and one
// bit per column, with a valid bit per row that a clear command drops at once, so
// neither a clear nor reset needs a sweep. A place word reads the rectangle's
// rows one at a time (a read state, then an accumulate state) and ORs them, then
// walks the columns of that anchor row one per cycle from the cursor; on a fit it
// rewrites each covered row (read, then write). The column walk and the single
// memory port set the rate. Clear and skip words answer in the cycle after they
// are taken. One word is in flight at a time; the response sits in an output
// register and the next word is taken once it has been taken.
module grid_rect_first_fit_packer import gfp_pkg::*; #(
   parameter int MAX_COLS = GFP_MAX_COLS,
   parameter int MAX_ROWS = GFP_MAX_ROWS
) (
   input logic        clock,
   input logic        reset,
   gfp_req_if.sink    req_ch,
   gfp_rsp_if.source  rsp_ch,
   gfp_csr_if.sink    csr_ch
);

   localparam int CI = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int RI = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CC = $clog2(MAX_COLS + 1);
   localparam int RC = $clog2(MAX_ROWS + 1);
   localparam int AW = GFP_PX_W + 1;

   // configuration registers
   logic [GFP_DIM_W-1:0]   grid_cols_ff, grid_rows_ff;
   logic [GFP_SHIFT_W-1:0] cell_shift_ff;
   logic [CC-1:0]          cols_eff;
   logic [RC-1:0]          rows_eff;

   // sequencer state
   gfp_state_type         state_ff, state_in;
   logic [CC-1:0]         cols_ff, cols_in;
   logic [RC-1:0]         rows_ff, rows_in;
   logic [GFP_PX_W-1:0]   w_ff, w_in, h_ff, h_in;
   logic [RC-1:0]         row_ff, row_in;
   logic [CC-1:0]         col_ff, col_in;
   logic [RC-1:0]         cnt_ff, cnt_in;
   logic [MAX_COLS-1:0]   acc_ff, acc_in, anc_ff, anc_in, mask_ff, mask_in;
   logic [CI-1:0]         cur_col_ff, cur_col_in;
   logic [RC-1:0]         cur_row_ff, cur_row_in;
   logic                  rsp_vld_ff, rsp_vld_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;
   logic [GFP_POS_W-1:0]  rsp_col_ff, rsp_col_in, rsp_row_ff, rsp_row_in;

   // memory and row valid bits
   logic [MAX_COLS-1:0]   occ_ff [MAX_ROWS];
   logic [MAX_ROWS-1:0]   rowv_ff;
   logic                  rd_v_ff;
   logic [MAX_COLS-1:0]   rd_data_ff, rd_row;
   logic                  mem_rd, mem_we, clear_all;
   logic [RI-1:0]         rd_addr, wr_addr;
   logic [MAX_COLS-1:0]   wr_data;

   // datapath helpers
   logic                  req_fire;
   logic [AW-1:0]         hsum, wsum, hh, cnt_next;
   logic                  h_fits, w_fits, last_rd, cell_free;
   logic [CI-1:0]         col_ix;
   logic [MAX_COLS-1:0]   wmask, win;
   logic [RI-1:0]         cur_addr;

   assign req_ch.ready   = (state_ff == S_IDLE) && !rsp_vld_ff;
   assign req_fire       = req_ch.valid && req_ch.ready;
   assign csr_ch.ready   = 1'b1;
   assign rsp_ch.valid   = rsp_vld_ff;
   assign rsp_ch.status  = rsp_status_ff;
   assign rsp_ch.pos_col = rsp_col_ff;
   assign rsp_ch.pos_row = rsp_row_ff;

   // clamp the size registers to 1..max
   always_comb begin
      if (grid_cols_ff == '0) cols_eff = CC'(1);
      else if (int'(grid_cols_ff) > MAX_COLS) cols_eff = CC'(MAX_COLS);
      else cols_eff = CC'(grid_cols_ff);
      if (grid_rows_ff == '0) rows_eff = RC'(1);
      else if (int'(grid_rows_ff) > MAX_ROWS) rows_eff = RC'(MAX_ROWS);
      else rows_eff = RC'(grid_rows_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_cols_ff  <= GFP_DIM_W'(64);
         grid_rows_ff  <= GFP_DIM_W'(64);
         cell_shift_ff <= GFP_SHIFT_W'(4);
      end else if (csr_ch.valid && csr_ch.ready) begin
         case (gfp_csr_ix_type'(csr_ch.index))
            CSR_GRID_COLS:  grid_cols_ff  <= csr_ch.data;
            CSR_GRID_ROWS:  grid_rows_ff  <= csr_ch.data;
            CSR_CELL_SHIFT: cell_shift_ff <= csr_ch.data[GFP_SHIFT_W-1:0];
            default: ;
         endcase
      end
   end

   // a row never written since the last clear reads as all free
   assign rd_row = rd_v_ff ? rd_data_ff : '0;

   always_ff @(posedge clock) begin
      if (mem_we) occ_ff[wr_addr] <= wr_data;
      if (mem_rd) begin
         rd_data_ff <= occ_ff[rd_addr];
         rd_v_ff    <= rowv_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear_all) rowv_ff <= '0;
      else if (mem_we) rowv_ff[wr_addr] <= 1'b1;
   end

   // rectangle geometry against the grid
   assign hsum     = AW'(row_ff) + AW'(h_ff);
   assign h_fits   = hsum <= AW'(rows_ff);
   assign wsum     = AW'(col_ff) + AW'(w_ff);
   assign w_fits   = wsum <= AW'(cols_ff);
   assign hh       = (h_ff == '0) ? AW'(1) : AW'(h_ff);
   assign cnt_next = AW'(cnt_ff) + AW'(1);
   assign last_rd  = cnt_next >= hh;
   assign cur_addr = RI'(row_ff + cnt_ff);
   assign col_ix   = col_ff[CI-1:0];

   always_comb begin
      for (int i = 0; i < MAX_COLS; i++) wmask[i] = (i < int'(w_ff));
   end

   assign win       = (acc_ff >> col_ix) & wmask;
   assign cell_free = !anc_ff[col_ix] && (win == '0);

   always_comb begin
      state_in      = state_ff;
      cols_in       = cols_ff;
      rows_in       = rows_ff;
      w_in          = w_ff;
      h_in          = h_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      cnt_in        = cnt_ff;
      acc_in        = acc_ff;
      anc_in        = anc_ff;
      mask_in       = mask_ff;
      cur_col_in    = cur_col_ff;
      cur_row_in    = cur_row_ff;
      rsp_vld_in    = rsp_vld_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_row_in    = rsp_row_ff;
      mem_rd        = 1'b0;
      mem_we        = 1'b0;
      clear_all     = 1'b0;
      rd_addr       = cur_addr;
      wr_addr       = cur_addr;
      wr_data       = rd_row | mask_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               rsp_col_in = '0;
               rsp_row_in = '0;
               if (gfp_cmd_type'(req_ch.command) == CMD_CLEAR) begin
                  // drop every row at once and home the cursor
                  clear_all     = 1'b1;
                  cur_col_in    = '0;
                  cur_row_in    = '0;
                  rsp_vld_in    = 1'b1;
                  rsp_status_in = ST_CLEARED;
               end else if (req_ch.excluded || req_ch.rect_width_px == '0 ||
                            req_ch.rect_height_px == '0) begin
                  rsp_vld_in    = 1'b1;
                  rsp_status_in = ST_SKIPPED;
               end else begin
                  w_in     = req_ch.rect_width_px >> cell_shift_ff;
                  h_in     = req_ch.rect_height_px >> cell_shift_ff;
                  cols_in  = cols_eff;
                  rows_in  = rows_eff;
                  row_in   = cur_row_ff;
                  col_in   = CC'(cur_col_ff);
                  state_in = S_ROW;
               end
            end
         end

         S_ROW: begin
            cnt_in = '0;
            acc_in = '0;
            if (row_ff >= rows_ff) begin
               // sweep exhausted: park the cursor past the last row
               cur_col_in    = '0;
               cur_row_in    = rows_ff;
               rsp_vld_in    = 1'b1;
               rsp_status_in = ST_NO_ROOM;
               state_in      = S_IDLE;
            end else if (!h_fits) begin
               row_in = row_ff + RC'(1);
               col_in = '0;
            end else begin
               state_in = S_RD;
            end
         end

         S_RD: begin
            mem_rd   = 1'b1;
            state_in = S_ACC;
         end

         S_ACC: begin
            // OR the rectangle's rows; keep the anchor row for the anchor test
            if (cnt_ff == '0) anc_in = rd_row;
            if (h_ff != '0) acc_in = acc_ff | rd_row;
            if (last_rd) begin
               state_in = S_SCAN;
            end else begin
               cnt_in   = cnt_ff + RC'(1);
               state_in = S_RD;
            end
         end

         S_SCAN: begin
            if (col_ff >= cols_ff || !w_fits) begin
               row_in   = row_ff + RC'(1);
               col_in   = '0;
               state_in = S_ROW;
            end else if (cell_free) begin
               mask_in    = wmask << col_ix;
               cnt_in     = '0;
               rsp_col_in = GFP_POS_W'(col_ff);
               rsp_row_in = GFP_POS_W'(row_ff);
               if (AW'(col_ff) + AW'(1) >= AW'(cols_ff)) begin
                  cur_col_in = '0;
                  cur_row_in = row_ff + RC'(1);
               end else begin
                  cur_col_in = col_ix + CI'(1);
                  cur_row_in = row_ff;
               end
               if (w_ff == '0 || h_ff == '0) begin
                  rsp_vld_in    = 1'b1;
                  rsp_status_in = ST_PLACED;
                  state_in      = S_IDLE;
               end else begin
                  state_in = S_MRD;
               end
            end else begin
               col_in = col_ff + CC'(1);
            end
         end

         S_MRD: begin
            mem_rd   = 1'b1;
            state_in = S_MWR;
         end

         S_MWR: begin
            // write back the row with the rectangle's cells taken
            mem_we = 1'b1;
            if (last_rd) begin
               rsp_vld_in    = 1'b1;
               rsp_status_in = ST_PLACED;
               state_in      = S_IDLE;
            end else begin
               cnt_in   = cnt_ff + RC'(1);
               state_in = S_MRD;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         cur_col_ff <= '0;
         cur_row_ff <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cur_col_ff <= cur_col_in;
         cur_row_ff <= cur_row_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cols_ff       <= cols_in;
      rows_ff       <= rows_in;
      w_ff          <= w_in;
      h_ff          <= h_in;
      row_ff        <= row_in;
      col_ff        <= col_in;
      cnt_ff        <= cnt_in;
      acc_ff        <= acc_in;
      anc_ff        <= anc_in;
      mask_ff       <= mask_in;
      rsp_status_ff <= rsp_status_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_row_ff    <= rsp_row_in;
   end

endmodule
